@@ hdl/uf2bf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uf2bf_pkg: shared types and constants for the UF2 block framer
// Frame constants, register indexes, queue entry type and the byte-wise
// CRC-32 (MSB first) lookup table.
// ----------------------------------------------------------------------------
package uf2bf_pkg;

  localparam int unsigned MAX_IMAGE_BYTES     = 65536;
  localparam int unsigned BLOCK_PAYLOAD_BYTES = 256;
  localparam int unsigned WORDS_PER_BLOCK     = BLOCK_PAYLOAD_BYTES / 4;
  localparam int unsigned PAD_WORDS           = 119 - WORDS_PER_BLOCK;
  localparam int unsigned HDR_WORDS           = 8;
  localparam int unsigned MAX_BLOCKS          = MAX_IMAGE_BYTES / BLOCK_PAYLOAD_BYTES;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned POS_W  = 6;
  localparam int unsigned BLK_W  = 8;
  localparam int unsigned CNT_W  = 9;
  localparam int unsigned SEQ_W  = 6;

  localparam logic [WORD_W-1:0] MAGIC_START0  = 32'h0A32_4655;
  localparam logic [WORD_W-1:0] MAGIC_START1  = 32'h9E5D_5157;
  localparam logic [WORD_W-1:0] UF2_FLAGS     = 32'h0000_2000;
  localparam logic [WORD_W-1:0] MAGIC_END     = 32'h0AB1_6F30;
  localparam logic [WORD_W-1:0] PAYLOAD_SIZE  = WORD_W'(BLOCK_PAYLOAD_BYTES);
  localparam logic [WORD_W-1:0] CRC_POLY      = 32'h04C1_1DB7;
  localparam logic [WORD_W-1:0] CRC_INIT      = 32'hFFFF_FFFF;
  localparam logic [WORD_W-1:0] RST_COUNT     = 32'h0000_0001;
  localparam logic [WORD_W-1:0] RST_BASE      = 32'h1000_0000;
  localparam logic [WORD_W-1:0] RST_FAMILY    = 32'hE48B_FF56;

  localparam int unsigned CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BLOCK_COUNT  = 2'd0,
    CFG_BASE_ADDRESS = 2'd1,
    CFG_FAMILY_ID    = 2'd2
  } cfg_index_t;

  typedef enum logic [2:0] {
    HDR_START0  = 3'd0,
    HDR_START1  = 3'd1,
    HDR_FLAGS   = 3'd2,
    HDR_ADDRESS = 3'd3,
    HDR_SIZE    = 3'd4,
    HDR_BLOCK   = 3'd5,
    HDR_COUNT   = 3'd6,
    HDR_FAMILY  = 3'd7
  } hdr_slot_t;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // One classified input word on its way to the back end
  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic [WORD_W-1:0] addr;
    logic [BLK_W-1:0]  blk;
    logic              hdr;   // first word of a block: header goes out first
    logic              tail;  // last word of a block: pad and end magic follow
    logic              last;  // final block of the image
  } entry_t;

  typedef logic [WORD_W-1:0] crc_table_t [256];

  function automatic crc_table_t crc_build_table();
    crc_table_t        t;
    logic [WORD_W-1:0] c;
    for (int i = 0; i < 256; i++) begin
      c = WORD_W'(i) << 24;
      for (int k = 0; k < 8; k++) begin
        c = c[31] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      t[i] = c;
    end
    return t;
  endfunction

  localparam crc_table_t CRC_TABLE = crc_build_table();

  function automatic logic [WORD_W-1:0] crc_byte(input logic [WORD_W-1:0] crc,
                                                 input logic [7:0] b);
    return {crc[23:0], 8'h00} ^ CRC_TABLE[crc[31:24] ^ b];
  endfunction

endpackage

@@ hdl/uf2bf_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uf2bf_in_if: image word channel
// Valid/ready channel carrying one 32-bit little-endian image word.
// ----------------------------------------------------------------------------
interface uf2bf_in_if;
  logic                         valid;
  logic                         ready;
  logic [uf2bf_pkg::WORD_W-1:0] data_word;

  modport source (output valid, output data_word, input ready);
  modport sink   (input valid, input data_word, output ready);
endinterface

@@ hdl/uf2bf_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uf2bf_out_if: UF2 stream channel
// Valid/ready channel carrying one UF2 word plus block and image end marks.
// ----------------------------------------------------------------------------
interface uf2bf_out_if;
  logic                         valid;
  logic                         ready;
  logic [uf2bf_pkg::WORD_W-1:0] out_word;
  logic                         block_end;
  logic                         image_end;

  modport source (output valid, output out_word, output block_end, output image_end,
                  input ready);
  modport sink   (input valid, input out_word, input block_end, input image_end,
                  output ready);
endinterface

@@ hdl/uf2bf_cfg_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uf2bf_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface uf2bf_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [uf2bf_pkg::CFG_IDX_W-1:0] index;
  logic [uf2bf_pkg::WORD_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hdl/uf2bf_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uf2bf_front: input classifier and boot CRC
// Tracks word position, block number and target address, runs the block-0
// CRC two bytes per cycle and pushes one classified entry per input word.
// ----------------------------------------------------------------------------
module uf2bf_front (
  input  logic                         clk,
  input  logic                         rst,
  uf2bf_in_if.sink                     image,
  input  logic [uf2bf_pkg::CNT_W-1:0]  count,
  input  logic [uf2bf_pkg::WORD_W-1:0] base_address,
  output logic                         push,
  output uf2bf_pkg::entry_t            push_entry,
  input  logic                         full
);
  import uf2bf_pkg::*;

  localparam logic [POS_W-1:0] POS_LAST = POS_W'(WORDS_PER_BLOCK - 1);

  logic [POS_W-1:0]  pos;
  logic [BLK_W-1:0]  blk;
  logic [WORD_W-1:0] crc;
  logic [WORD_W-1:0] target;
  logic              busy;   // second half of a block-0 CRC word in progress
  logic [15:0]       upper;

  logic              accept;
  logic              blk0;
  logic              at_last;
  logic              fresh;
  logic              last;
  logic [WORD_W-1:0] crc_base;
  logic [WORD_W-1:0] addr_cur;

  always_comb begin
    image.ready = !full && !busy;
    accept      = image.valid && image.ready;
    blk0        = (blk == '0);
    at_last     = (pos == POS_LAST);
    fresh       = blk0 && (pos == '0);
    crc_base    = fresh ? CRC_INIT : crc;
    addr_cur    = fresh ? base_address : target;
    last        = (({1'b0, blk} + CNT_W'(1)) >= count);

    push            = accept;
    push_entry.word = (blk0 && at_last) ? crc : image.data_word;
    push_entry.addr = addr_cur;
    push_entry.blk  = blk;
    push_entry.hdr  = (pos == '0);
    push_entry.tail = at_last;
    push_entry.last = last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos    <= '0;
      blk    <= '0;
      crc    <= CRC_INIT;
      target <= RST_BASE;
      busy   <= 1'b0;
    end else if (busy) begin
      crc  <= crc_byte(crc_byte(crc, upper[7:0]), upper[15:8]);
      busy <= 1'b0;
    end else if (accept) begin
      if (blk0 && !at_last) begin
        crc   <= crc_byte(crc_byte(crc_base, image.data_word[7:0]),
                          image.data_word[15:8]);
        upper <= image.data_word[31:16];
        busy  <= 1'b1;
      end
      if (at_last) begin
        target <= addr_cur + PAYLOAD_SIZE;
        pos    <= '0;
        if (last) begin
          blk <= '0;
          crc <= CRC_INIT;
        end else begin
          blk <= blk + BLK_W'(1);
        end
      end else begin
        target <= addr_cur;
        pos    <= pos + POS_W'(1);
      end
    end
  end

endmodule

@@ hdl/uf2bf_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uf2bf_fifo: entry queue
// Short first-word-fall-through queue between the front and back ends.
// ----------------------------------------------------------------------------
module uf2bf_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  uf2bf_pkg::entry_t push_entry,
  output logic              full,
  input  logic              pop,
  output uf2bf_pkg::entry_t head,
  output logic              empty
);
  import uf2bf_pkg::*;

  entry_t                slots [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;
  logic [FIFO_CNT_W-1:0] fill;

  assign full  = (fill == FIFO_CNT_W'(FIFO_DEPTH));
  assign empty = (fill == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + FIFO_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_PTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + FIFO_CNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - FIFO_CNT_W'(1);
      end
    end
  end

endmodule

@@ hdl/uf2bf_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uf2bf_back: UF2 word sequencer
// Expands queue entries into header, data, padding and end magic words,
// one word per cycle into a registered output stage when not stalled.
// ----------------------------------------------------------------------------
module uf2bf_back (
  input  logic                         clk,
  input  logic                         rst,
  input  uf2bf_pkg::entry_t            head,
  input  logic                         empty,
  output logic                         pop,
  input  logic [uf2bf_pkg::CNT_W-1:0]  count,
  input  logic [uf2bf_pkg::WORD_W-1:0] family_id,
  uf2bf_out_if.source                  stream
);
  import uf2bf_pkg::*;

  typedef enum logic [3:0] {
    ST_HDR  = 4'b0001,
    ST_DATA = 4'b0010,
    ST_PAD  = 4'b0100,
    ST_END  = 4'b1000
  } back_state_t;

  localparam logic [SEQ_W-1:0] HDR_LAST = SEQ_W'(HDR_WORDS - 1);
  localparam logic [SEQ_W-1:0] PAD_LAST = SEQ_W'(PAD_WORDS - 1);

  back_state_t       state, state_next;
  logic [SEQ_W-1:0]  seq, seq_next;
  logic              ovalid;
  logic [WORD_W-1:0] oword, oword_next;
  logic              oblock_end, oblock_end_next;
  logic              oimage_end, oimage_end_next;
  logic              load;
  logic              go;
  logic [WORD_W-1:0] hdr_word;

  always_comb begin
    unique case (hdr_slot_t'(seq[2:0]))
      HDR_START0:  hdr_word = MAGIC_START0;
      HDR_START1:  hdr_word = MAGIC_START1;
      HDR_FLAGS:   hdr_word = UF2_FLAGS;
      HDR_ADDRESS: hdr_word = head.addr;
      HDR_SIZE:    hdr_word = PAYLOAD_SIZE;
      HDR_BLOCK:   hdr_word = WORD_W'(head.blk);
      HDR_COUNT:   hdr_word = WORD_W'(count);
      HDR_FAMILY:  hdr_word = family_id;
      default:     hdr_word = MAGIC_START0;
    endcase
  end

  always_comb begin
    load            = !ovalid || stream.ready;
    go              = load && !empty;
    state_next      = state;
    seq_next        = seq;
    pop             = 1'b0;
    oword_next      = oword;
    oblock_end_next = 1'b0;
    oimage_end_next = 1'b0;
    if (go) begin
      unique case (state)
        ST_HDR: begin
          if (head.hdr) begin
            oword_next = hdr_word;
            seq_next   = seq + SEQ_W'(1);
            if (seq == HDR_LAST) begin
              state_next = ST_DATA;
              seq_next   = '0;
            end
          end else begin
            // no header on this entry: data word goes straight out
            oword_next = head.word;
            seq_next   = '0;
            if (head.tail) begin
              state_next = ST_PAD;
            end else begin
              pop = 1'b1;
            end
          end
        end
        ST_DATA: begin
          oword_next = head.word;
          seq_next   = '0;
          if (head.tail) begin
            state_next = ST_PAD;
          end else begin
            pop        = 1'b1;
            state_next = ST_HDR;
          end
        end
        ST_PAD: begin
          oword_next = '0;
          seq_next   = seq + SEQ_W'(1);
          if (seq == PAD_LAST) begin
            state_next = ST_END;
            seq_next   = '0;
          end
        end
        ST_END: begin
          oword_next      = MAGIC_END;
          oblock_end_next = 1'b1;
          oimage_end_next = head.last;
          pop             = 1'b1;
          state_next      = ST_HDR;
          seq_next        = '0;
        end
        default: begin
          state_next = ST_HDR;
          seq_next   = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_HDR;
      seq    <= '0;
      ovalid <= 1'b0;
    end else begin
      state <= state_next;
      seq   <= seq_next;
      if (load) begin
        ovalid <= go;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      oword      <= oword_next;
      oblock_end <= oblock_end_next;
      oimage_end <= oimage_end_next;
    end
  end

  assign stream.valid     = ovalid;
  assign stream.out_word  = oword;
  assign stream.block_end = oblock_end;
  assign stream.image_end = oimage_end;

endmodule

@@ hdl/uf2_block_framer_with_boot_crc.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uf2_block_framer_with_boot_crc: UF2 block framer with boot CRC
// Turns a stream of 32-bit image words into 128-word UF2 blocks.
// ----------------------------------------------------------------------------
// Every 64 image words produce one 128-word UF2 block; the output stage moves
// one word per cycle unless the sink stalls it or the queue is empty. In
// block 0 the front end folds each word into the boot CRC two bytes per
// cycle, so it takes no new word there until the previous word's CRC is
// done; a four-entry queue decouples it from the sequencer. Word 63 of block
// 0 is replaced by the CRC of the first 252 bytes. Registers (block count,
// base address, family id) may be written only while the framer is idle. The
// base address takes effect at the next block 0; block count and family id
// take effect at the next header or block end that reads them, even in the
// middle of an image. A block count of 0 acts as 1 and anything above 256
// acts as 256.
// ----------------------------------------------------------------------------
module uf2_block_framer_with_boot_crc (
  input  logic        clk,
  input  logic        rst,
  uf2bf_in_if.sink    image,
  uf2bf_out_if.source stream,
  uf2bf_cfg_if.sink   cfg
);
  import uf2bf_pkg::*;

  logic [CNT_W-1:0]  block_count;
  logic [WORD_W-1:0] base_address;
  logic [WORD_W-1:0] family_id;
  logic [CNT_W-1:0]  count;

  logic   push;
  entry_t push_entry;
  logic   full;
  logic   pop;
  entry_t head;
  logic   empty;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_count  <= CNT_W'(RST_COUNT);
      base_address <= RST_BASE;
      family_id    <= RST_FAMILY;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        CFG_BLOCK_COUNT:  block_count  <= cfg.data[CNT_W-1:0];
        CFG_BASE_ADDRESS: base_address <= cfg.data;
        CFG_FAMILY_ID:    family_id    <= cfg.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (block_count == '0) begin
      count = CNT_W'(1);
    end else if (block_count > CNT_W'(MAX_BLOCKS)) begin
      count = CNT_W'(MAX_BLOCKS);
    end else begin
      count = block_count;
    end
  end

  uf2bf_front u_front (
    .clk          (clk),
    .rst          (rst),
    .image        (image),
    .count        (count),
    .base_address (base_address),
    .push         (push),
    .push_entry   (push_entry),
    .full         (full)
  );

  uf2bf_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .pop        (pop),
    .head       (head),
    .empty      (empty)
  );

  uf2bf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .empty     (empty),
    .pop       (pop),
    .count     (count),
    .family_id (family_id),
    .stream    (stream)
  );

  ap_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("queue popped while empty");

  ap_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("queue pushed while full");

  ap_image_end_closes_block: assert property (@(posedge clk) disable iff (rst)
    (stream.valid && stream.image_end) |-> (stream.block_end && stream.out_word == MAGIC_END))
    else $error("image end mark off the end magic word");

endmodule
